/* rtl/llcd_pkg.sv */
// ----------------------------------------------------------------------------
// Ladder level classify and debounce: shared types and constants
// Beat payload types, field widths, register indexes and reset values used
// by the classifier and debounce unit.
// ----------------------------------------------------------------------------
package llcd_pkg;

  // Field widths fixed by the beat formats.
  localparam int unsigned PinW    = 3;
  localparam int unsigned SampleW = 10;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned SegW    = 3;
  localparam int unsigned HoldW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // Number of level registers in the register map.
  localparam int unsigned LevelSlots = 6;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CfgMatchMargin = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHoldMs      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLevelSeg1   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLevelSeg2   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLevelSeg3   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLevelSeg4   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgLevelSeg5   = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgLevelSeg6   = 3'd7;

  // Register reset values.
  localparam logic [SampleW-1:0] MarginReset = 10'd20;
  localparam logic [HoldW-1:0]   HoldReset   = 16'd50;

  // Segment code meaning that no segment matched.
  localparam logic [SegW-1:0] SegNone = 3'd0;

  // Input beat.
  typedef struct packed {
    logic [PinW-1:0]    pin_index;
    logic [SampleW-1:0] sample;
    logic [TimeW-1:0]   now_ms;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [PinW-1:0] out_pin;
    logic [SegW-1:0] stable_seg;
  } out_item_t;

endpackage

/* rtl/ladder_level_classify_debounce_unit.sv */
// ----------------------------------------------------------------------------
// Ladder level classify and debounce unit
// Classifies ADC samples of keys on a resistor ladder into segments and
// debounces the segment per pin against a millisecond hold time.
// ----------------------------------------------------------------------------
// Each input beat passes an input register and a result register. A sample
// held in the input register is loaded into the result register once the
// result channel is free to take it, and its result is presented from there.
// The unit takes one sample per cycle and only stalls input while a result
// waits on a stalled result channel. The per-pin state (previous candidate,
// change time, stable segment) is read and written in the logic between the
// two registers, so back-to-back samples of the same pin see each other's
// updates. The six window compares against level +/- margin, the 32-bit
// wrapping time difference and the hold compare all lie between the two
// registers as well. A sample for a pin at or beyond NUM_PINS leaves all
// state untouched and reports segment 0.
// Registers should be written only while no samples are in flight.
module ladder_level_classify_debounce_unit #(
  parameter int unsigned NUM_PINS     = 8,
  parameter int unsigned NUM_SEGMENTS = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Sample channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  llcd_pkg::in_item_t          in_item_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output llcd_pkg::out_item_t         out_item_o,
  // Register write port
  input  logic                        cfg_we_i,
  input  logic [llcd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [llcd_pkg::CfgW-1:0]   cfg_data_i
);
  import llcd_pkg::*;

  localparam int unsigned PinIdxW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

  // Configuration registers.
  logic [SampleW-1:0] margin_q;
  logic [HoldW-1:0]   hold_q;
  logic [SampleW-1:0] level_q [LevelSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MarginReset;
      hold_q   <= HoldReset;
      for (int i = 0; i < LevelSlots; i++) begin
        level_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMatchMargin: margin_q <= cfg_data_i[SampleW-1:0];
        CfgHoldMs:      hold_q   <= cfg_data_i[HoldW-1:0];
        CfgLevelSeg1:   level_q[0] <= cfg_data_i[SampleW-1:0];
        CfgLevelSeg2:   level_q[1] <= cfg_data_i[SampleW-1:0];
        CfgLevelSeg3:   level_q[2] <= cfg_data_i[SampleW-1:0];
        CfgLevelSeg4:   level_q[3] <= cfg_data_i[SampleW-1:0];
        CfgLevelSeg5:   level_q[4] <= cfg_data_i[SampleW-1:0];
        CfgLevelSeg6:   level_q[5] <= cfg_data_i[SampleW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake and pipeline control.
  logic     s1_valid_q, s1_valid_d;
  in_item_t s1_item_q;
  logic     out_valid_q, out_valid_d;
  out_item_t out_item_q;
  logic     out_free;
  logic     adv2;
  logic     load1;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv2       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign load1      = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (load1) begin
      s1_valid_d = 1'b1;
    end else if (adv2) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (adv2) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (load1) begin
      s1_item_q <= in_item_i;
    end
  end

  // Pin lookup: range check and state index.
  logic                  pin_ok;
  logic [PinIdxW+PinW-1:0] pin_ext;
  logic [PinIdxW-1:0]    pin_idx;

  assign pin_ok  = ({29'd0, s1_item_q.pin_index} < 32'(NUM_PINS));
  assign pin_ext = {{PinIdxW{1'b0}}, s1_item_q.pin_index};
  assign pin_idx = pin_ext[PinIdxW-1:0];

  // Window compares; the highest matching segment wins.
  logic [SegW-1:0] cand;

  always_comb begin
    logic [SampleW:0] s_plus_m;
    logic [SampleW:0] lv_plus_m;
    s_plus_m = {1'b0, s1_item_q.sample} + {1'b0, margin_q};
    cand     = SegNone;
    for (int k = 0; k < NUM_SEGMENTS && k < LevelSlots; k++) begin
      lv_plus_m = {1'b0, level_q[k]} + {1'b0, margin_q};
      if (s_plus_m >= {1'b0, level_q[k]} && {1'b0, s1_item_q.sample} <= lv_plus_m) begin
        cand = SegW'(k + 1);
      end
    end
  end

  // Per-pin debounce state.
  logic [SegW-1:0]  prev_cand_q  [NUM_PINS];
  logic [TimeW-1:0] change_time_q [NUM_PINS];
  logic [SegW-1:0]  acc_seg_q    [NUM_PINS];

  logic [SegW-1:0]  prev_rd;
  logic [TimeW-1:0] change_rd;
  logic [SegW-1:0]  acc_rd;
  logic             cand_changed;
  logic [TimeW-1:0] elapsed;
  logic             take_cand;
  logic [SegW-1:0]  acc_next;
  logic             upd_en;

  always_comb begin
    prev_rd   = SegNone;
    change_rd = '0;
    acc_rd    = SegNone;
    if (pin_ok) begin
      prev_rd   = prev_cand_q[pin_idx];
      change_rd = change_time_q[pin_idx];
      acc_rd    = acc_seg_q[pin_idx];
    end
  end

  // A changed candidate restarts the timer, so it can never be taken at once.
  assign cand_changed = (cand != prev_rd);
  assign elapsed      = s1_item_q.now_ms - change_rd;
  assign take_cand    = !cand_changed && (elapsed > {{(TimeW-HoldW){1'b0}}, hold_q});
  assign acc_next     = take_cand ? cand : acc_rd;
  assign upd_en       = adv2 && pin_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PINS; i++) begin
        prev_cand_q[i]   <= SegNone;
        change_time_q[i] <= '0;
        acc_seg_q[i]     <= SegNone;
      end
    end else if (upd_en) begin
      prev_cand_q[pin_idx] <= cand;
      acc_seg_q[pin_idx]   <= acc_next;
      if (cand_changed) begin
        change_time_q[pin_idx] <= s1_item_q.now_ms;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (adv2) begin
      out_item_q.out_pin    <= s1_item_q.pin_index;
      out_item_q.stable_seg <= pin_ok ? acc_next : SegNone;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks on the pipeline and the per-pin state.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  a_bad_pin_reports_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv2 && !pin_ok) |=> out_item_q.stable_seg == SegNone)
    else $error("out-of-range pin reported a segment");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_en |=> out_item_q.stable_seg == acc_seg_q[$past(pin_idx)])
    else $error("result differs from stored stable segment");

  a_change_restarts_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_en && cand_changed) |=>
      change_time_q[$past(pin_idx)] == $past(s1_item_q.now_ms))
    else $error("candidate change did not restart the timer");

endmodule

/* dv/ladder_level_classify_debounce_unit_tb.sv */
// ----------------------------------------------------------------------------
// Ladder level classify and debounce unit: testbench
// Drives ADC sample beats with random gaps and result stalls. It programs the
// margin, hold time and six segment levels in several settings, predicts each
// pin's debounced segment, and checks every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ladder_level_classify_debounce_unit_tb;
  import llcd_pkg::*;

  localparam int ClkHalf       = 10;
  localparam int NumPins       = 8;
  localparam int NumSegs       = 6;
  localparam int WatchdogLimit = 500;
  localparam int PhaseItems    = 165;

  // Per-pin debounce tracker: mirrors the unit's registers and state and
  // holds the debounced segments that are still due on the result channel.
  class seg_debounce_scoreboard;
    logic [SampleW-1:0] margin;
    logic [HoldW-1:0]   hold;
    logic [SampleW-1:0] level [LevelSlots];
    logic [SegW-1:0]    last_cand [NumPins];
    logic [TimeW-1:0]   change_ms [NumPins];
    logic [SegW-1:0]    stable [NumPins];
    out_item_t          stable_seg_q [$];
    int unsigned        n_samples;
    int unsigned        n_results;
    int unsigned        n_errors;

    function new();
      margin = MarginReset;
      hold   = HoldReset;
      foreach (level[i]) level[i] = '0;
      foreach (last_cand[i]) begin
        last_cand[i] = SegNone;
        change_ms[i] = '0;
        stable[i]    = SegNone;
      end
      n_samples = 0;
      n_results = 0;
      n_errors  = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CfgMatchMargin: margin = data[SampleW-1:0];
        CfgHoldMs:      hold   = data[HoldW-1:0];
        default:        level[idx - CfgLevelSeg1] = data[SampleW-1:0];
      endcase
    endfunction

    // Window match with signed bounds; the highest matching segment wins.
    function logic [SegW-1:0] classify_sample(logic [SampleW-1:0] s);
      int sv;
      int mv;
      int lv;
      logic [SegW-1:0] found;
      sv    = int'(s);
      mv    = int'(margin);
      found = SegNone;
      for (int k = 1; k <= NumSegs; k++) begin
        lv = int'(level[k-1]);
        if (sv >= lv - mv && sv <= lv + mv) found = SegW'(k);
      end
      return found;
    endfunction

    function void note_sample(in_item_t it);
      logic [SegW-1:0]  cand;
      logic [TimeW-1:0] elapsed;
      out_item_t        want;
      int               p;
      p               = int'(it.pin_index);
      want.out_pin    = it.pin_index;
      want.stable_seg = SegNone;
      if (p < NumPins) begin
        cand = classify_sample(it.sample);
        if (cand != last_cand[p]) change_ms[p] = it.now_ms;
        elapsed = it.now_ms - change_ms[p];
        if (elapsed > TimeW'(hold)) stable[p] = cand;
        last_cand[p]    = cand;
        want.stable_seg = stable[p];
      end
      stable_seg_q.push_back(want);
      n_samples++;
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      n_errors++;
      if (n_errors <= 10)
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      n_results++;
      if (stable_seg_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("[%0t] result beat with none due: pin %0d seg %0d",
                   $time, got.out_pin, got.stable_seg);
      end else begin
        want = stable_seg_q.pop_front();
        if (got.out_pin !== want.out_pin) report("out_pin", want.out_pin, got.out_pin);
        if (got.stable_seg !== want.stable_seg)
          report("stable_seg", want.stable_seg, got.stable_seg);
      end
    endfunction

    function int pending();
      return stable_seg_q.size();
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  in_item_t            in_item_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgW-1:0]     cfg_data_i  = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  out_item_t           out_item_o;

  seg_debounce_scoreboard sb = new();

  logic [TimeW-1:0] clk_ms;
  int               focus_pin = 0;
  int               target_seg [NumPins];
  int               send_burst = 0;
  int               stall_run = 0;
  int               free_run = 0;
  int               quiet_cycles = 0;
  int               n_settings = 0;

  ladder_level_classify_debounce_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Idle length: mostly short, now and then long.
  function int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Sender gap, with occasional stretches of back-to-back beats.
  function int pick_gap();
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    if ($urandom_range(0, 99) < 4) begin
      send_burst = $urandom_range(20, 80);
      return 0;
    end
    if ($urandom_range(0, 99) < 50) return 0;
    return idle_len();
  endfunction

  // Result side: check accepted beats, then pick the next stall level.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
      if (stall_run == 0 && free_run == 0) begin
        free_run  = ($urandom_range(0, 99) < 8) ? $urandom_range(30, 80)
                                                : $urandom_range(0, 12);
        stall_run = idle_len();
      end
      if (free_run > 0) begin
        free_run--;
        out_stall_i <= 1'b0;
      end else begin
        stall_run--;
        out_stall_i <= 1'b1;
      end
    end
  end

  // Watchdog: too many cycles without a beat on either channel ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no beat for %0d cycles", WatchdogLimit);
        $display("FAIL ladder_level_classify_debounce_unit");
        $finish;
      end
    end
  end

  // Offer one sample beat and hold it until the unit takes it.
  task automatic send_sample(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_sample(it);
  endtask

  task automatic send_at(input int pin, input int smp, input logic [TimeW-1:0] now);
    in_item_t it;
    it.pin_index = PinW'(pin);
    it.sample    = SampleW'(smp);
    it.now_ms    = now;
    send_sample(it);
  endtask

  // Stop offering samples and let every result drain out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all eight registers back to back; spare upper data bits are random.
  task automatic program_ladder(input logic [SampleW-1:0] margin,
                                input logic [HoldW-1:0] hold,
                                input logic [SampleW-1:0] lv [LevelSlots]);
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]    data;
    for (int r = 0; r < 2 + LevelSlots; r++) begin
      if (r == 0) begin
        idx  = CfgMatchMargin;
        data = {6'($urandom), margin};
      end else if (r == 1) begin
        idx  = CfgHoldMs;
        data = hold;
      end else begin
        idx  = CfgLevelSeg1 + CfgIdxW'(r - 2);
        data = {6'($urandom), lv[r-2]};
      end
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= data;
      @(posedge clk_i);
      sb.write_reg(idx, data);
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Mostly per-pin runs that aim at one segment with the clock moving
  // forward; the rest is noise with random pins, samples and times.
  task automatic run_traffic(input int n);
    in_item_t it;
    int       k;
    int       v;
    int       m;
    int       h;
    int       q;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 99) < 40) focus_pin = $urandom_range(0, NumPins - 1);
        if ($urandom_range(0, 99) < 12) target_seg[focus_pin] = $urandom_range(0, NumSegs);
        k = target_seg[focus_pin];
        m = int'(sb.margin);
        if (k == 0) begin
          v = $urandom_range(0, 1023);
        end else begin
          v = int'(sb.level[k-1]) + int'($urandom_range(0, 2 * m + 6)) - (m + 3);
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
        end
        h = int'(sb.hold);
        q = $urandom_range(0, 99);
        if (q < 85) clk_ms += $urandom_range(0, h / 6 + 2);
        else if (q < 97) clk_ms += $urandom_range(h / 2, h + 2);
        else clk_ms += $urandom_range(0, 2 * h + 100);
        it.pin_index = PinW'(focus_pin);
        it.sample    = SampleW'(v);
        it.now_ms    = clk_ms;
      end else begin
        it.pin_index = PinW'($urandom);
        it.sample    = SampleW'($urandom);
        it.now_ms    = ($urandom_range(0, 1) == 1) ? clk_ms : TimeW'($urandom);
      end
      send_sample(it);
    end
  endtask

  initial begin
    logic [SampleW-1:0] lv [LevelSlots];
    logic [SampleW-1:0] margin;
    logic [HoldW-1:0]   hold;
    foreach (target_seg[i]) target_seg[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: all levels at zero, so low samples land in segment six.
    clk_ms = $urandom;
    run_traffic(80);
    drain();

    // Directed: zero hold, time wrap, inclusive bounds, overlap and scale ends.
    lv = '{10'd0, 10'd150, 10'd400, 10'd440, 10'd850, 10'd1023};
    program_ladder(10'd30, 16'd0, lv);
    send_at(0, 0, 32'd0);
    send_at(0, 0, 32'd1);
    send_at(0, 1023, 32'd2);
    send_at(0, 1023, 32'd3);
    send_at(7, 1023, 32'hFFFF_FFFF);
    send_at(7, 1000, 32'd0);
    send_at(1, 370, 32'd10);
    send_at(1, 369, 32'd11);
    send_at(1, 420, 32'd12);
    send_at(1, 420, 32'd13);
    send_at(1, 470, 32'd14);
    send_at(1, 471, 32'd15);
    drain();

    // Directed: zero margin, longest hold reached exactly and then passed.
    lv = '{10'd1023, 10'd0, 10'd512, 10'd512, 10'd1, 10'd1022};
    program_ladder(10'd0, 16'hFFFF, lv);
    send_at(2, 512, 32'd100);
    send_at(2, 511, 32'd101);
    send_at(3, 1023, 32'd5);
    send_at(3, 1023, 32'd5 + 32'd65535);
    send_at(3, 1023, 32'd5 + 32'd65536);
    drain();

    // Random phases over a spread of register settings.
    for (int p = 0; p < 8; p++) begin
      foreach (lv[i]) lv[i] = SampleW'($urandom);
      case (p)
        0: begin
          margin = 10'd20;
          hold   = 16'd50;
          lv     = '{10'd100, 10'd250, 10'd400, 10'd550, 10'd700, 10'd850};
        end
        1: begin
          margin = 10'd0;
          hold   = 16'd0;
        end
        2: begin
          margin = 10'd1023;
          hold   = 16'hFFFF;
        end
        3: begin
          margin = 10'd10;
          hold   = 16'd1;
          lv     = '{10'd0, 10'd0, 10'd1023, 10'd1023, 10'd5, 10'd1018};
        end
        4: begin
          margin = SampleW'($urandom_range(0, 60));
          hold   = HoldW'($urandom_range(0, 300));
        end
        5: begin
          margin = 10'd5;
          hold   = 16'd200;
          lv     = '{10'd60, 10'd180, 10'd300, 10'd420, 10'd540, 10'd660};
        end
        6: begin
          margin = SampleW'($urandom);
          hold   = HoldW'($urandom);
        end
        default: begin
          margin = 10'd40;
          hold   = 16'd3;
          lv     = '{10'd500, 10'd510, 10'd520, 10'd530, 10'd540, 10'd550};
        end
      endcase
      program_ladder(margin, hold, lv);
      // Odd phases start just short of the 32-bit wrap of the clock.
      clk_ms = (p % 2 == 1) ? 32'hFFFF_FFFF - TimeW'($urandom_range(0, 5000))
                            : TimeW'($urandom);
      run_traffic(PhaseItems);
      drain();
    end

    $display("Covered %0d samples on %0d pins under %0d register settings.",
             sb.n_samples, NumPins, n_settings + 1);
    $display("Checked %0d result beats, %0d mismatches.", sb.n_results, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("PASS ladder_level_classify_debounce_unit");
    end else begin
      $display("FAIL ladder_level_classify_debounce_unit");
    end
    $finish;
  end

endmodule
